// ===== sv/tolf_pkg.sv =====
// Shared types, constants and helpers for the terminal output line filter.
`default_nettype none

package tolf_pkg;

   localparam int COUNT_BITS = 25;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] BUDGET_RESET = COUNT_BITS'(8388608);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_BEL = 8'h07;
   localparam logic [7:0] CHAR_BS = 8'h08;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_ESC = 8'h1B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CSI_FINAL_LO = 8'h40;
   localparam logic [7:0] CHAR_CSI_FINAL_HI = 8'h7E;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_ERASE  = 3'd1,
      OP_CLEAR  = 3'd2,
      OP_END    = 3'd3,
      OP_RUNEND = 3'd4
   } tolf_op_type;

   typedef struct packed {
      tolf_op_type edit_op;
      logic [7:0] data_byte;
      logic newline_kept;
      logic [COUNT_BITS-1:0] line_length;
      logic truncated;
      logic last;
   } tolf_result_type;

   typedef struct packed {
      logic [1:0] valid;
      tolf_result_type item1;
      tolf_result_type item0;
   } tolf_push_type;

   function automatic tolf_result_type make_result(
      input tolf_op_type op,
      input logic [7:0] data,
      input logic kept,
      input logic [COUNT_BITS-1:0] len,
      input logic trunc
   );
      tolf_result_type r;
      r.edit_op = op;
      r.data_byte = data;
      r.newline_kept = kept;
      r.line_length = len;
      r.truncated = trunc;
      r.last = 1'b0;
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/tolf_core.sv =====
// Escape stripping, line editing and budget accounting for one byte per cycle while step is high.
`default_nettype none

module tolf_core import tolf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  wire logic [7:0] byte_in,
   input  wire logic flush,
   input  wire logic csr_write,
   input  wire logic [COUNT_BITS-1:0] csr_data,
   output tolf_push_type push
);

   typedef enum logic [2:0] {
      ESC_TEXT    = 3'd0,
      ESC_SEEN    = 3'd1,
      ESC_CSI     = 3'd2,
      ESC_OSC     = 3'd3,
      ESC_OSC_ESC = 3'd4
   } esc_state_type;

   esc_state_type esc_ff, esc_in;
   logic cr_ff, cr_in;
   logic [COUNT_BITS-1:0] len_ff, len_in;
   logic [COUNT_BITS-1:0] charged_ff, charged_in;
   logic dropped_ff, dropped_in;
   logic [COUNT_BITS-1:0] budget_ff, budget_in;

   logic spent;
   logic printable;
   logic [COUNT_BITS-1:0] len_after_cr;
   tolf_result_type clear_item;
   tolf_result_type app_item;
   tolf_push_type push_raw;

   assign spent = (charged_ff >= budget_ff) || (charged_ff == COUNT_MAX);
   assign printable = (byte_in == CHAR_TAB) || (byte_in >= CHAR_SPACE);
   assign len_after_cr = cr_ff ? '0 : len_ff;
   assign clear_item = make_result(OP_CLEAR, 8'h00, 1'b0, '0, dropped_ff);
   assign app_item = make_result(OP_APPEND, byte_in, 1'b0,
                                 len_after_cr + COUNT_BITS'(1), dropped_ff);
   assign budget_in = csr_write ? csr_data : budget_ff;

   always_comb begin
      esc_in = esc_ff;
      cr_in = cr_ff;
      len_in = len_ff;
      charged_in = charged_ff;
      dropped_in = dropped_ff;
      push_raw = '0;
      if (step) begin
         if (flush) begin
            if (!cr_ff && (len_ff != '0)) begin
               push_raw.valid = 2'b11;
               push_raw.item0 = make_result(OP_END, 8'h00, !spent, '0,
                                            spent | dropped_ff);
               push_raw.item1 = make_result(OP_RUNEND, 8'h00, 1'b0, '0,
                                            spent | dropped_ff);
            end else begin
               push_raw.valid = 2'b01;
               push_raw.item0 = make_result(OP_RUNEND, 8'h00, 1'b0, '0, dropped_ff);
            end
            esc_in = ESC_TEXT;
            cr_in = 1'b0;
            len_in = '0;
            charged_in = '0;
            dropped_in = 1'b0;
         end else begin
            case (esc_ff)
               ESC_TEXT: begin
                  if (byte_in == CHAR_ESC) begin
                     esc_in = ESC_SEEN;
                  end else if (byte_in == CHAR_CR) begin
                     cr_in = 1'b1;
                  end else if (byte_in == CHAR_LF) begin
                     cr_in = 1'b0;
                     len_in = '0;
                     if (!spent) begin
                        charged_in = charged_ff + COUNT_BITS'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                     push_raw.valid = 2'b01;
                     push_raw.item0 = make_result(OP_END, 8'h00, !spent, '0,
                                                  spent | dropped_ff);
                  end else if (byte_in == CHAR_BS) begin
                     if (cr_ff) begin
                        cr_in = 1'b0;
                        len_in = '0;
                        push_raw.valid = 2'b01;
                        push_raw.item0 = clear_item;
                     end else if (len_ff != '0) begin
                        len_in = len_ff - COUNT_BITS'(1);
                        push_raw.valid = 2'b01;
                        push_raw.item0 = make_result(OP_ERASE, 8'h00, 1'b0,
                                                     len_ff - COUNT_BITS'(1), dropped_ff);
                     end
                  end else begin
                     if (cr_ff) begin
                        cr_in = 1'b0;
                        len_in = '0;
                        push_raw.valid[0] = 1'b1;
                        push_raw.item0 = clear_item;
                     end
                     if (printable) begin
                        if (spent) begin
                           dropped_in = 1'b1;
                        end else begin
                           len_in = len_after_cr + COUNT_BITS'(1);
                           charged_in = charged_ff + COUNT_BITS'(1);
                           if (cr_ff) begin
                              push_raw.valid[1] = 1'b1;
                              push_raw.item1 = app_item;
                           end else begin
                              push_raw.valid[0] = 1'b1;
                              push_raw.item0 = app_item;
                           end
                        end
                     end
                  end
               end
               ESC_SEEN: begin
                  if (byte_in == CHAR_LBRACKET) begin
                     esc_in = ESC_CSI;
                  end else if (byte_in == CHAR_RBRACKET) begin
                     esc_in = ESC_OSC;
                  end else begin
                     esc_in = ESC_TEXT;
                  end
               end
               ESC_CSI: begin
                  if ((byte_in >= CHAR_CSI_FINAL_LO) && (byte_in <= CHAR_CSI_FINAL_HI)) begin
                     esc_in = ESC_TEXT;
                  end
               end
               ESC_OSC: begin
                  if (byte_in == CHAR_BEL) begin
                     esc_in = ESC_TEXT;
                  end else if (byte_in == CHAR_ESC) begin
                     esc_in = ESC_OSC_ESC;
                  end
               end
               ESC_OSC_ESC: begin
                  esc_in = (byte_in == CHAR_BACKSLASH) ? ESC_TEXT : ESC_OSC;
               end
               default: begin
                  esc_in = ESC_TEXT;
               end
            endcase
         end
      end
   end

   always_comb begin
      push = push_raw;
      push.item0.last = push_raw.valid[0] & ~push_raw.valid[1];
      push.item1.last = push_raw.valid[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= ESC_TEXT;
         cr_ff <= 1'b0;
         len_ff <= '0;
         charged_ff <= '0;
         dropped_ff <= 1'b0;
         budget_ff <= BUDGET_RESET;
      end else begin
         esc_ff <= esc_in;
         cr_ff <= cr_in;
         len_ff <= len_in;
         charged_ff <= charged_in;
         dropped_ff <= dropped_in;
         budget_ff <= budget_in;
      end
   end

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (step && flush) |=> (esc_ff == ESC_TEXT) && !cr_ff && (len_ff == '0)
                          && (charged_ff == '0) && !dropped_ff)
      else $error("State not cleared after a flush.");

   a_len_within_charged: assert property (@(posedge clock) disable iff (reset)
      len_ff <= charged_ff)
      else $error("Pending line longer than the charged count.");

   a_push_in_order: assert property (@(posedge clock) disable iff (reset)
      push.valid[1] |-> push.valid[0])
      else $error("Second result pushed without a first.");

   a_no_push_while_idle: assert property (@(posedge clock) disable iff (reset)
      !step |-> (push.valid == 2'b00))
      else $error("Result pushed without an accepted beat.");

endmodule

`default_nettype wire

// ===== sv/tolf_queue.sv =====
// Result queue that takes up to two result beats per cycle and delivers one while out_ready is high.
`default_nettype none

module tolf_queue import tolf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  tolf_push_type push,
   output logic room,
   output logic out_valid,
   input  wire logic out_ready,
   output tolf_result_type out_item
);

   tolf_result_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_PTR_BITS-1:0] wr_next;
   logic pop;
   logic [QUEUE_CNT_BITS-1:0] push_n;

   assign out_valid = (count_ff != '0);
   assign out_item = entry_ff[rd_ptr_ff];
   assign room = (count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
   assign pop = out_valid & out_ready;
   assign push_n = QUEUE_CNT_BITS'(push.valid[0]) + QUEUE_CNT_BITS'(push.valid[1]);
   assign wr_next = wr_ptr_ff + QUEUE_PTR_BITS'(1);
   assign wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
   assign count_in = count_ff + push_n - QUEUE_CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push.valid[0]) begin
         entry_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.valid[1]) begin
         entry_ff[wr_next] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("Result queue overfilled.");

   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      (push.valid != 2'b00) |-> ($past(room) || $past(reset)) || room)
      else $error("Result pushed without room.");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push.valid == 2'b00) && pop |=> count_ff == $past(count_ff) - QUEUE_CNT_BITS'(1))
      else $error("Queue count lost track of a pop.");

endmodule

`default_nettype wire

// ===== sv/terminal_output_line_filter.sv =====
// Top level of the terminal output line filter: escape stripper with a result queue.
// The result beats of a byte are registered in the result queue before they are offered.
// Throughput: one input byte per cycle while results are taken; a byte yields 0 to 2 beats.
// The input stalls while the four-entry result queue holds more than two beats.
// Synchronous reset returns all line state to text mode, sets the budget to 8388608
// and empties the queue; there is no clearing pass.
`default_nettype none

module terminal_output_line_filter import tolf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [7:0] req_byte_in,
   input  wire logic req_flush,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [2:0] rsp_edit_op,
   output logic [7:0] rsp_data_byte,
   output logic rsp_newline_kept,
   output logic [COUNT_BITS-1:0] rsp_line_length,
   output logic rsp_truncated,
   output logic rsp_last,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [COUNT_BITS-1:0] csr_output_budget
);

   tolf_push_type push;
   tolf_result_type head;
   logic room;
   logic step;

   assign req_ready = room;
   assign step = req_valid & room;
   assign csr_ready = 1'b1;

   tolf_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .byte_in   (req_byte_in),
      .flush     (req_flush),
      .csr_write (csr_valid),
      .csr_data  (csr_output_budget),
      .push      (push)
   );

   tolf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_item  (head)
   );

   assign rsp_edit_op = head.edit_op;
   assign rsp_data_byte = head.data_byte;
   assign rsp_newline_kept = head.newline_kept;
   assign rsp_line_length = head.line_length;
   assign rsp_truncated = head.truncated;
   assign rsp_last = head.last;

   a_flush_ends_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_flush) |=> rsp_valid)
      else $error("No result beat after a flush beat.");

   a_kept_only_on_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_newline_kept) |-> (rsp_edit_op == OP_END))
      else $error("Newline kept flag on a beat that is not an end of line.");

   a_runend_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_edit_op == OP_RUNEND)) |-> rsp_last && (rsp_line_length == '0))
      else $error("Run end beat is not the final beat of its byte.");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the terminal output line filter.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tolf_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES = 300;
   localparam int SIDE_REQ = 0;
   localparam int SIDE_RSP = 1;

   typedef enum logic [2:0] {
      SCAN_TEXT,
      SCAN_ESC,
      SCAN_CSI,
      SCAN_OSC,
      SCAN_OSC_ESC
   } scan_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_byte_in = 8'd0;
   logic req_flush = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_edit_op;
   logic [7:0] rsp_data_byte;
   logic rsp_newline_kept;
   logic [COUNT_BITS-1:0] rsp_line_length;
   logic rsp_truncated;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_BITS-1:0] csr_output_budget = '0;

   scan_phase_type scan_phase = SCAN_TEXT;
   logic cr_waiting = 1'b0;
   logic [COUNT_BITS-1:0] line_fill = '0;
   logic [COUNT_BITS-1:0] charged = '0;
   logic dropped = 1'b0;
   logic [COUNT_BITS-1:0] budget = BUDGET_RESET;

   tolf_result_type step_edits [2];
   int step_count;
   tolf_result_type pending_edits [$];

   int mismatches = 0;
   int edits_seen = 0;
   int beats_sent = 0;
   int cycle_count = 0;
   int calm_left [2] = '{0, 0};
   int stall_left = 0;
   bit steady_sender = 1'b0;
   bit pressure_req = 1'b0;
   logic hold_off = 1'b0;

   terminal_output_line_filter i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_byte_in(req_byte_in),
      .req_flush(req_flush),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_edit_op(rsp_edit_op),
      .rsp_data_byte(rsp_data_byte),
      .rsp_newline_kept(rsp_newline_kept),
      .rsp_line_length(rsp_line_length),
      .rsp_truncated(rsp_truncated),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_output_budget(csr_output_budget)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int idle_length(input int side);
      int roll;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         calm_left[side] = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic bit budget_spent();
      return (charged >= budget) || (charged == COUNT_MAX);
   endfunction

   function automatic void add_edit(input tolf_op_type op, input logic [7:0] data,
                                    input logic kept, input logic [COUNT_BITS-1:0] len);
      tolf_result_type r;
      r.edit_op = op;
      r.data_byte = data;
      r.newline_kept = kept;
      r.line_length = len;
      r.truncated = dropped;
      r.last = 1'b0;
      step_edits[step_count] = r;
      step_count++;
   endfunction

   function automatic void predict_end_line();
      logic kept;
      kept = 1'b0;
      if (!budget_spent()) begin
         charged = charged + 1'b1;
         kept = 1'b1;
      end else begin
         dropped = 1'b1;
      end
      line_fill = '0;
      add_edit(OP_END, 8'd0, kept, '0);
   endfunction

   function automatic void predict_clear();
      if (cr_waiting) begin
         cr_waiting = 1'b0;
         line_fill = '0;
         add_edit(OP_CLEAR, 8'd0, 1'b0, '0);
      end
   endfunction

   function automatic void predict_beat(input logic [7:0] value, input logic flush);
      step_count = 0;
      if (flush) begin
         if (cr_waiting) begin
            cr_waiting = 1'b0;
            line_fill = '0;
         end
         if (line_fill != 0) predict_end_line();
         add_edit(OP_RUNEND, 8'd0, 1'b0, '0);
         scan_phase = SCAN_TEXT;
         cr_waiting = 1'b0;
         line_fill = '0;
         charged = '0;
         dropped = 1'b0;
      end else begin
         case (scan_phase)
            SCAN_TEXT: begin
               if (value == CHAR_ESC) begin
                  scan_phase = SCAN_ESC;
               end else if (value == CHAR_CR) begin
                  cr_waiting = 1'b1;
               end else if (value == CHAR_LF) begin
                  cr_waiting = 1'b0;
                  predict_end_line();
               end else if (value == CHAR_BS) begin
                  predict_clear();
                  if (line_fill != 0) begin
                     line_fill = line_fill - 1'b1;
                     add_edit(OP_ERASE, 8'd0, 1'b0, line_fill);
                  end
               end else begin
                  predict_clear();
                  if (value == CHAR_TAB || value >= CHAR_SPACE) begin
                     if (budget_spent()) begin
                        dropped = 1'b1;
                     end else begin
                        line_fill = line_fill + 1'b1;
                        charged = charged + 1'b1;
                        add_edit(OP_APPEND, value, 1'b0, line_fill);
                     end
                  end
               end
            end
            SCAN_ESC: begin
               if (value == CHAR_LBRACKET) scan_phase = SCAN_CSI;
               else if (value == CHAR_RBRACKET) scan_phase = SCAN_OSC;
               else scan_phase = SCAN_TEXT;
            end
            SCAN_CSI: begin
               if (value >= CHAR_CSI_FINAL_LO && value <= CHAR_CSI_FINAL_HI) begin
                  scan_phase = SCAN_TEXT;
               end
            end
            SCAN_OSC: begin
               if (value == CHAR_BEL) scan_phase = SCAN_TEXT;
               else if (value == CHAR_ESC) scan_phase = SCAN_OSC_ESC;
            end
            SCAN_OSC_ESC: begin
               scan_phase = (value == CHAR_BACKSLASH) ? SCAN_TEXT : SCAN_OSC;
            end
            default: begin
               scan_phase = SCAN_TEXT;
            end
         endcase
      end
      if (step_count > 0) step_edits[step_count-1].last = 1'b1;
      for (int i = 0; i < step_count; i++) pending_edits.push_back(step_edits[i]);
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 50) begin
         $display("MISMATCH at result beat %0d, %s: got 0x%0h, expected 0x%0h",
                  edits_seen, field, got, want);
      end
      mismatches++;
   endtask

   task automatic check_edit();
      tolf_result_type want;
      if (pending_edits.size() == 0) begin
         report_mismatch("beat with nothing expected", {29'd0, rsp_edit_op}, 32'd0);
      end else begin
         want = pending_edits.pop_front();
         if (rsp_edit_op !== want.edit_op)
            report_mismatch("edit_op", {29'd0, rsp_edit_op}, {29'd0, want.edit_op});
         if (rsp_data_byte !== want.data_byte)
            report_mismatch("data_byte", {24'd0, rsp_data_byte}, {24'd0, want.data_byte});
         if (rsp_newline_kept !== want.newline_kept)
            report_mismatch("newline_kept", {31'd0, rsp_newline_kept},
                            {31'd0, want.newline_kept});
         if (rsp_line_length !== want.line_length)
            report_mismatch("line_length", {7'd0, rsp_line_length}, {7'd0, want.line_length});
         if (rsp_truncated !== want.truncated)
            report_mismatch("truncated", {31'd0, rsp_truncated}, {31'd0, want.truncated});
         if (rsp_last !== want.last)
            report_mismatch("last", {31'd0, rsp_last}, {31'd0, want.last});
      end
      edits_seen++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_edit();
      if (hold_off) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = idle_length(SIDE_RSP);
      end
   end

   // The receiver stalls once for a long stretch so that the result queue fills up.
   initial begin
      int held;
      wait (pressure_req);
      @(posedge clock);
      hold_off <= 1'b1;
      held = 0;
      while (held < HOLD_CYCLES) begin
         @(posedge clock);
         held++;
      end
      hold_off <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_beat(input logic [7:0] value, input logic flush);
      int gap;
      req_valid <= 1'b1;
      req_byte_in <= value;
      req_flush <= flush;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_beat(value, flush);
      beats_sent++;
      gap = steady_sender ? 0 : idle_length(SIDE_REQ);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_beat(text[i], 1'b0);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_edits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_budget(input logic [COUNT_BITS-1:0] value);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_output_budget <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      budget = value;
   endtask

   task automatic test_line_edits();
      send_beat(CHAR_BS, 1'b0);
      send_beat(CHAR_SPACE, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(CHAR_TAB, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(CHAR_BS, 1'b0);
      send_beat(CHAR_CR, 1'b0);
      send_beat(8'h7E, 1'b0);
      send_beat(CHAR_CR, 1'b0);
      send_beat(CHAR_BS, 1'b0);
      send_beat(CHAR_CR, 1'b0);
      send_beat(8'h01, 1'b0);
      send_beat(CHAR_LF, 1'b0);
      send_text("A");
      send_beat(CHAR_CR, 1'b0);
      send_beat(8'h00, 1'b1);
   endtask

   task automatic test_escape_sequences();
      send_beat(CHAR_ESC, 1'b0);
      send_text("[5~");
      send_beat(CHAR_ESC, 1'b0);
      send_text("]a");
      send_beat(CHAR_BEL, 1'b0);
      send_beat(CHAR_ESC, 1'b0);
      send_text("]");
      send_beat(CHAR_ESC, 1'b0);
      send_text("x");
      send_beat(CHAR_ESC, 1'b0);
      send_beat(CHAR_BACKSLASH, 1'b0);
      send_beat(CHAR_ESC, 1'b0);
      send_text("Qb");
      send_beat(8'hA5, 1'b1);
   endtask

   task automatic test_budget_limits();
      write_budget('0);
      send_text("a");
      send_beat(CHAR_LF, 1'b0);
      send_beat(8'h5A, 1'b1);
      write_budget(COUNT_BITS'(2));
      send_text("abc");
      send_beat(CHAR_BS, 1'b0);
      send_beat(CHAR_LF, 1'b0);
      send_beat(8'hFF, 1'b1);
   endtask

   task automatic test_backpressure();
      write_budget(COUNT_BITS'(1000));
      steady_sender = 1'b1;
      pressure_req = 1'b1;
      for (int i = 0; i < 40; i++) send_beat(8'h41 + 8'(i % 26), 1'b0);
      send_beat(8'h00, 1'b1);
      steady_sender = 1'b0;
   endtask

   task automatic send_random_run();
      int tokens;
      int roll;
      int n;
      tokens = $urandom_range(2, 15);
      repeat (tokens) begin
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            n = $urandom_range(1, 8);
            repeat (n) send_beat(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
         end else if (roll < 45) begin
            send_beat(CHAR_LF, 1'b0);
         end else if (roll < 52) begin
            send_beat(CHAR_CR, 1'b0);
         end else if (roll < 58) begin
            n = $urandom_range(1, 3);
            repeat (n) send_beat(CHAR_BS, 1'b0);
         end else if (roll < 70) begin
            send_beat(CHAR_ESC, 1'b0);
            send_beat(CHAR_LBRACKET, 1'b0);
            n = $urandom_range(0, 4);
            repeat (n) send_beat(8'($urandom_range(8'h20, 8'h3F)), 1'b0);
            send_beat(8'($urandom_range(CHAR_CSI_FINAL_LO, CHAR_CSI_FINAL_HI)), 1'b0);
         end else if (roll < 78) begin
            send_beat(CHAR_ESC, 1'b0);
            send_beat(CHAR_RBRACKET, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) send_beat(8'($urandom_range(8'h20, 8'h7E)), 1'b0);
            if ($urandom_range(0, 3) == 0) begin
               send_beat(CHAR_ESC, 1'b0);
               send_beat(8'($urandom_range(8'h20, 8'h5B)), 1'b0);
            end
            if ($urandom_range(0, 1) == 0) begin
               send_beat(CHAR_BEL, 1'b0);
            end else begin
               send_beat(CHAR_ESC, 1'b0);
               send_beat(CHAR_BACKSLASH, 1'b0);
            end
         end else if (roll < 83) begin
            send_beat(CHAR_ESC, 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b0);
         end else if (roll < 88) begin
            send_beat(8'($urandom_range(0, 31)), 1'b0);
         end else if (roll < 98) begin
            n = $urandom_range(1, 4);
            repeat (n) send_beat(8'($urandom_range(0, 255)), 1'b0);
         end else begin
            send_beat(8'($urandom_range(0, 255)), 1'b1);
         end
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic test_random_runs();
      logic [COUNT_BITS-1:0] budgets [4];
      int start;
      budgets[0] = COUNT_BITS'(16777216);
      budgets[1] = COUNT_BITS'($urandom_range(1, 40));
      budgets[2] = COUNT_BITS'($urandom_range(41, 400));
      budgets[3] = BUDGET_RESET;
      for (int p = 0; p < 4; p++) begin
         write_budget(budgets[p]);
         start = beats_sent;
         while (beats_sent - start < 120) send_random_run();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_line_edits();
      test_escape_sequences();
      test_budget_limits();
      test_backpressure();
      test_random_runs();
      wait_quiet();
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
